[hw/rtl/dilm_pkg.sv]
// Shared constants and types for the DER IMEI list matcher.
`default_nettype none
package dilm_pkg;

	localparam int unsigned ImeiW  = 60;
	localparam int unsigned CountW = 17;
	localparam int unsigned LenW   = 16;
	localparam int unsigned PosW   = 5;

	// DER tags and markers
	localparam logic [7:0] SEQ_TAG  = 8'h30;
	localparam logic [7:0] LEN_TAG  = 8'h82;
	localparam logic [7:0] ELEM_TAG = 8'h0C;
	localparam logic [7:0] ELEM_LEN = 8'h0F;
	localparam logic [7:0] WILDCARD = 8'h2A;

	// position of the final byte inside a 17-byte element
	localparam logic [PosW-1:0] ELEM_LAST_POS = 5'd16;
	localparam logic [CountW-1:0] COUNT_MAX   = 17'h1FFFF;
	localparam logic [CountW-1:0] HEADER_BYTES = 17'd4;

	// verdict codes
	localparam logic [2:0] ST_MATCH     = 3'd0;
	localparam logic [2:0] ST_NO_MATCH  = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT = 3'd2;
	localparam logic [2:0] ST_BAD_TAGS  = 3'd3;
	localparam logic [2:0] ST_LEN_MISM  = 3'd4;

	typedef struct packed {
		logic       allowed;
		logic [2:0] status;
	} dilm_verdict_t;

endpackage
`default_nettype wire

[hw/rtl/dilm_walker.sv]
// Header check, element walk and verdict for one extension value.
`default_nettype none
module dilm_walker import dilm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        data_s1,
	input  wire logic              last_s1,
	input  wire logic [ImeiW-1:0]  imei,
	output dilm_verdict_t          verdict
);

	logic [CountW-1:0] count_q, count_n;
	logic [LenW-1:0]   len_q, len_n;
	logic              hbad_q, hbad_n;
	logic [PosW-1:0]   pos_q, pos_n;
	logic              elem_ok_q, elem_ok_n;
	logic              stopped_q, stopped_n;
	logic              seen_q, seen_n;
	logic [3:0]        digit;
	logic [7:0]        exp_char;

	// pick the expected character for a digit index, first digit on top
	function automatic logic [7:0] expected_char(input logic [ImeiW-1:0] v,
			input logic [3:0] d);
		logic [3:0] nib;
		nib = 4'd0;
		for (int k = 0; k < 15; k++) begin
			if (d == 4'(k)) nib = v[(14-k)*4 +: 4];
		end
		return {4'h3, nib};
	endfunction

	assign digit    = 4'(pos_q - 5'd2);
	assign exp_char = expected_char(imei, digit);

	// next state for one byte
	always_comb begin
		count_n   = count_q;
		len_n     = len_q;
		hbad_n    = hbad_q;
		pos_n     = pos_q;
		elem_ok_n = elem_ok_q;
		stopped_n = stopped_q;
		seen_n    = seen_q;
		if (step) begin
			case (count_q)
				17'd0: if (data_s1 != SEQ_TAG) hbad_n = 1'b1;
				17'd1: if (data_s1 != LEN_TAG) hbad_n = 1'b1;
				17'd2: len_n = {data_s1, len_q[7:0]};
				17'd3: len_n = {len_q[15:8], data_s1};
				default: begin
					if (!stopped_q) begin
						if (pos_q == 5'd0 && data_s1 != ELEM_TAG) begin
							stopped_n = 1'b1;
						end else if (pos_q == 5'd1 && data_s1 != ELEM_LEN) begin
							stopped_n = 1'b1;
						end else begin
							if (pos_q >= 5'd2 && elem_ok_q && data_s1 != WILDCARD &&
									data_s1 != exp_char)
								elem_ok_n = 1'b0;
							if (pos_q == ELEM_LAST_POS) begin
								if (elem_ok_n) seen_n = 1'b1;
								pos_n     = '0;
								elem_ok_n = 1'b1;
							end else begin
								pos_n = pos_q + 5'd1;
							end
						end
					end
				end
			endcase
			if (count_q != COUNT_MAX) count_n = count_q + 17'd1;
		end
	end

	// verdict from the state after this byte
	always_comb begin
		verdict.allowed = 1'b0;
		if (count_n <= HEADER_BYTES)
			verdict.status = ST_TOO_SHORT;
		else if (hbad_n)
			verdict.status = ST_BAD_TAGS;
		else if (({1'b0, len_n} + HEADER_BYTES) != count_n)
			verdict.status = ST_LEN_MISM;
		else if (seen_n) begin
			verdict.status  = ST_MATCH;
			verdict.allowed = 1'b1;
		end else
			verdict.status = ST_NO_MATCH;
	end

	// advance state; clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			len_q     <= '0;
			hbad_q    <= 1'b0;
			pos_q     <= '0;
			elem_ok_q <= 1'b1;
			stopped_q <= 1'b0;
			seen_q    <= 1'b0;
		end else if (step && last_s1) begin
			count_q   <= '0;
			len_q     <= '0;
			hbad_q    <= 1'b0;
			pos_q     <= '0;
			elem_ok_q <= 1'b1;
			stopped_q <= 1'b0;
			seen_q    <= 1'b0;
		end else begin
			count_q   <= count_n;
			len_q     <= len_n;
			hbad_q    <= hbad_n;
			pos_q     <= pos_n;
			elem_ok_q <= elem_ok_n;
			stopped_q <= stopped_n;
			seen_q    <= seen_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= ELEM_LAST_POS)
		else $error("element position out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (count_q == '0 && elem_ok_q && !seen_q))
		else $error("state not cleared after final byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> (stopped_q || $past(step && last_s1)))
		else $error("walk resumed after malformed element");

endmodule
`default_nettype wire

[hw/rtl/der_imei_list_matcher_core.sv]
// Top level of the DER IMEI list matcher: input register, walker, result register.
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  in      | in_valid, in_stall, data_byte,    | to block
//          | last_byte                         |
//  out     | out_valid, out_stall,             | from block
//          | imei_allowed, status              |
//  cfg     | cfg_we, cfg_wdata                 | to block
//
// One byte per cycle while in_stall is low; a final byte passes the input register and then
// the result register, where its verdict is offered and held until out_stall is low.
// A stalled verdict holds only a following final byte; other bytes keep flowing.
// Reset clears the walker state, the valid flags and the IMEI register.
`default_nettype none
module der_imei_list_matcher_core import dilm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      logic             imei_allowed,
	output      logic [2:0]       status,
	input  wire logic             cfg_we,
	input  wire logic [ImeiW-1:0] cfg_wdata
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic             step;
	logic             in_take;
	logic [ImeiW-1:0] imei_q;
	dilm_verdict_t    verdict;
	logic             out_valid_q;
	dilm_verdict_t    out_q;

	// a final byte moves on only when the result register is free
	assign step     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	// hold the IMEI register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) imei_q <= '0;
		else if (cfg_we) imei_q <= cfg_wdata;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_take) valid_s1 <= 1'b1;
		else if (step) valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	dilm_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.imei    (imei_q),
		.verdict (verdict)
	);

	// result register: load on a final byte, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (step && last_s1) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) out_q <= verdict;
	end

	assign out_valid    = out_valid_q;
	assign imei_allowed = out_q.allowed;
	assign status       = out_q.status;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && imei_allowed) |-> (status == ST_MATCH))
		else $error("allowed without match status");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked verdict");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step && last_s1))
		else $error("verdict without a final byte");

endmodule
`default_nettype wire

[bench/dilm_verdict_checker.sv]
// Channel monitor for the DER IMEI list matcher: predicts each verdict and compares it.
module dilm_verdict_checker import dilm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire logic             imei_allowed,
	input  wire logic [2:0]       status,
	input  wire logic             cfg_we,
	input  wire logic [ImeiW-1:0] cfg_wdata,
	output int                    mismatch_count,
	output int                    verdicts_pending
);

	// predictor copy of the register and of the walker state
	logic [ImeiW-1:0]  imei_copy;
	logic [CountW-1:0] seen_bytes;
	logic [LenW-1:0]   stated_len;
	logic              tags_wrong;
	logic [PosW-1:0]   elem_pos;
	logic              elem_ok;
	logic              walk_halted;
	logic              hit_found;

	dilm_verdict_t verdicts_due[$];
	dilm_verdict_t oldest;

	// character the device IMEI holds at digit d of an element
	function automatic logic [7:0] imei_char(input int unsigned d);
		return 8'h30 + {4'h0, imei_copy[(14 - d) * 4 +: 4]};
	endfunction

	task automatic clear_walk();
		seen_bytes  = '0;
		stated_len  = '0;
		tags_wrong  = 1'b0;
		elem_pos    = '0;
		elem_ok     = 1'b1;
		walk_halted = 1'b0;
		hit_found   = 1'b0;
	endtask

	// advance the prediction by one item; queue a verdict on the final byte
	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		dilm_verdict_t v;
		if (seen_bytes == 0) begin
			if (b != SEQ_TAG) tags_wrong = 1'b1;
		end else if (seen_bytes == 1) begin
			if (b != LEN_TAG) tags_wrong = 1'b1;
		end else if (seen_bytes == 2) begin
			stated_len[15:8] = b;
		end else if (seen_bytes == 3) begin
			stated_len[7:0] = b;
		end else if (!walk_halted) begin
			if (elem_pos == 0 && b != ELEM_TAG) begin
				walk_halted = 1'b1;
			end else if (elem_pos == 1 && b != ELEM_LEN) begin
				walk_halted = 1'b1;
			end else begin
				// a digit mismatch sticks until the element ends
				if (elem_pos >= 2 && elem_ok && b != WILDCARD && b != imei_char(elem_pos - 2))
					elem_ok = 1'b0;
				if (elem_pos == ELEM_LAST_POS) begin
					if (elem_ok) hit_found = 1'b1;
					elem_pos = '0;
					elem_ok  = 1'b1;
				end else begin
					elem_pos = elem_pos + 1'b1;
				end
			end
		end
		// saturate the count so an overlong value never fits its length
		if (seen_bytes != COUNT_MAX) seen_bytes = seen_bytes + 1'b1;
		if (fin) begin
			v.allowed = 1'b0;
			if (seen_bytes <= HEADER_BYTES) begin
				v.status = ST_TOO_SHORT;
			end else if (tags_wrong) begin
				v.status = ST_BAD_TAGS;
			end else if ({1'b0, stated_len} + HEADER_BYTES != seen_bytes) begin
				v.status = ST_LEN_MISM;
			end else if (hit_found) begin
				v.status  = ST_MATCH;
				v.allowed = 1'b1;
			end else begin
				v.status = ST_NO_MATCH;
			end
			verdicts_due.push_back(v);
			clear_walk();
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imei_copy = '0;
			clear_walk();
			verdicts_due.delete();
			mismatch_count = 0;
			verdicts_pending <= 0;
		end else begin
			if (cfg_we === 1'b1) imei_copy = cfg_wdata;
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (verdicts_due.size() == 0) begin
					$error("unexpected verdict: imei_allowed=%0d status=%0d", imei_allowed, status);
					mismatch_count++;
				end else begin
					oldest = verdicts_due.pop_front();
					if (imei_allowed !== oldest.allowed) begin
						$error("imei_allowed: expected %0d, actual %0d", oldest.allowed,
							imei_allowed);
						mismatch_count++;
					end
					if (status !== oldest.status) begin
						$error("status: expected %0d, actual %0d", oldest.status, status);
						mismatch_count++;
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) absorb_byte(data_byte, last_byte);
			verdicts_pending <= verdicts_due.size();
		end
	end

endmodule

[bench/tb_top.sv]
// Bench top for the DER IMEI list matcher: clock, reset, stimulus and final verdict.
module tb_top;
	import dilm_pkg::*;

	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned PhaseBytes = 450;
	localparam int unsigned LongHold   = 400;

	typedef enum int {EL_EXACT, EL_WILD, EL_MISS, EL_RANDOM, EL_BAD_TAG, EL_BAD_LEN} elem_kind_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [7:0]       data_byte = 8'h00;
	logic             last_byte = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             imei_allowed;
	logic [2:0]       status;
	logic             cfg_we    = 1'b0;
	logic [ImeiW-1:0] cfg_wdata = '0;

	int               mismatch_count;
	int               verdicts_pending;
	logic [ImeiW-1:0] imei_setting = '0;
	logic [7:0]       ext_bytes[$];
	bit               sender_steady   = 1'b0;
	bit               receiver_steady = 1'b0;
	bit               hold_verdicts   = 1'b0;
	int unsigned      cycle_count;
	int unsigned      phase_bytes;

	always #5 clk = ~clk;

	der_imei_list_matcher_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.imei_allowed (imei_allowed),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	dilm_verdict_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.imei_allowed     (imei_allowed),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.mismatch_count   (mismatch_count),
		.verdicts_pending (verdicts_pending)
	);

	// character that matches digit d of the current setting
	function automatic logic [7:0] digit_char(input int unsigned d);
		return 8'h30 + {4'h0, imei_setting[(14 - d) * 4 +: 4]};
	endfunction

	function automatic elem_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30) return EL_EXACT;
		if (r < 55) return EL_WILD;
		if (r < 75) return EL_MISS;
		if (r < 88) return EL_RANDOM;
		if (r < 94) return EL_BAD_TAG;
		return EL_BAD_LEN;
	endfunction

	task automatic write_imei(input logic [ImeiW-1:0] v);
		imei_setting = v;
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic put_header(input logic [15:0] len);
		ext_bytes.push_back(SEQ_TAG);
		ext_bytes.push_back(LEN_TAG);
		ext_bytes.push_back(len[15:8]);
		ext_bytes.push_back(len[7:0]);
	endtask

	// append one 17-byte element of the given kind
	task automatic put_element(input elem_kind_t kind);
		int unsigned bad_digit;
		logic [7:0]  c;
		bad_digit = $urandom_range(0, 14);
		case (kind)
			EL_BAD_TAG: begin
				do c = 8'($urandom); while (c == ELEM_TAG);
				ext_bytes.push_back(c);
				ext_bytes.push_back(ELEM_LEN);
			end
			EL_BAD_LEN: begin
				ext_bytes.push_back(ELEM_TAG);
				do c = 8'($urandom); while (c == ELEM_LEN);
				ext_bytes.push_back(c);
			end
			default: begin
				ext_bytes.push_back(ELEM_TAG);
				ext_bytes.push_back(ELEM_LEN);
			end
		endcase
		for (int unsigned d = 0; d < 15; d++) begin
			c = digit_char(d);
			case (kind)
				EL_WILD: begin
					if ($urandom_range(0, 3) == 0) c = WILDCARD;
				end
				EL_MISS: begin
					// one wrong digit, then anything at all
					if (d == bad_digit) begin
						do c = 8'($urandom); while (c == digit_char(d) || c == WILDCARD);
					end else if (d > bad_digit) begin
						c = 8'($urandom);
					end
				end
				EL_RANDOM: begin
					c = ($urandom_range(0, 3) == 0) ? WILDCARD : 8'h30 + 8'($urandom_range(0, 15));
				end
				EL_BAD_TAG, EL_BAD_LEN: begin
					c = 8'($urandom);
				end
				default: ;
			endcase
			ext_bytes.push_back(c);
		end
	endtask

	// append the first len bytes of a matching element
	task automatic put_partial(input int unsigned len);
		for (int unsigned k = 0; k < len; k++) begin
			if (k == 0) ext_bytes.push_back(ELEM_TAG);
			else if (k == 1) ext_bytes.push_back(ELEM_LEN);
			else ext_bytes.push_back(digit_char(k - 2));
		end
	endtask

	// build one random extension value, mostly well formed
	task automatic make_value();
		int unsigned shape;
		int unsigned n;
		int unsigned r;
		logic [15:0] stated;
		logic [15:0] true_len;
		logic [7:0]  c;
		ext_bytes.delete();
		shape = $urandom_range(0, 99);
		if (shape < 8) begin
			// too short, often a proper header prefix
			n = $urandom_range(1, 4);
			for (int unsigned k = 0; k < n; k++) ext_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 1) == 1) begin
				ext_bytes[0] = SEQ_TAG;
				if (n > 1) ext_bytes[1] = LEN_TAG;
			end
		end else if (shape < 16) begin
			// noise
			n = $urandom_range(5, 40);
			for (int unsigned k = 0; k < n; k++) ext_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 1) == 1) ext_bytes[0] = SEQ_TAG;
		end else begin
			put_header(16'd0);
			n = $urandom_range(0, 4);
			for (int unsigned k = 0; k < n; k++) put_element(pick_kind());
			if ($urandom_range(0, 4) == 0) put_partial($urandom_range(1, 16));
			true_len = 16'(ext_bytes.size() - 4);
			stated   = true_len;
			if (shape < 26) begin
				do begin
					if ($urandom_range(0, 1) == 1) stated = 16'($urandom);
					else stated = true_len + 16'($urandom_range(0, 34)) - 16'd17;
				end while (stated == true_len);
			end
			ext_bytes[2] = stated[15:8];
			ext_bytes[3] = stated[7:0];
			if (shape >= 26 && shape < 34) begin
				r = $urandom_range(0, 1);
				do c = 8'($urandom); while (c == ((r == 0) ? SEQ_TAG : LEN_TAG));
				ext_bytes[r] = c;
			end
		end
	endtask

	// offer one item and hold it until it is taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		gap = sender_steady ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	task automatic send_value();
		foreach (ext_bytes[i]) send_byte(ext_bytes[i], i == ext_bytes.size() - 1);
	endtask

	// drop valid and wait until every verdict has been taken
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// receiver: random hold-off per verdict, one long hold-off on request
	initial begin
		int unsigned wait_cycles;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_verdicts) begin
				hold_verdicts = 1'b0;
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
			end else begin
				if ($urandom_range(0, 9) == 0) receiver_steady = !receiver_steady;
				wait_cycles = receiver_steady ? 0 : $urandom_range(0, 18);
				if (wait_cycles != 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [ImeiW-1:0] setting;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_imei(60'h353456789012345);

		// too short, with both extremes of the byte
		ext_bytes.delete();
		ext_bytes.push_back(8'hFF);
		send_value();
		ext_bytes.delete();
		ext_bytes.push_back(8'h00);
		ext_bytes.push_back(8'hFF);
		send_value();
		// header alone is still too short
		ext_bytes.delete();
		put_header(16'd0);
		send_value();
		// correct header, no complete element
		ext_bytes.delete();
		put_header(16'd1);
		ext_bytes.push_back(8'h00);
		send_value();
		// wrong second tag
		ext_bytes.delete();
		put_header(16'd1);
		ext_bytes[1] = 8'h81;
		ext_bytes.push_back(8'hFF);
		send_value();
		// declared length does not fit
		ext_bytes.delete();
		put_header(16'hFFFF);
		ext_bytes.push_back(ELEM_TAG);
		send_value();
		// one element with wildcards
		ext_bytes.delete();
		put_header(16'd17);
		put_element(EL_WILD);
		send_value();
		// element cut short by the end of the value
		ext_bytes.delete();
		put_header(16'd3);
		put_partial(3);
		send_value();
		settle();

		// random phases over several register settings
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: setting = '0;
				1: setting = '1;
				2: begin
					setting = '0;
					for (int k = 0; k < 15; k++)
						setting = {setting[ImeiW-5:0], 4'($urandom_range(0, 9))};
				end
				default: setting = ImeiW'({$urandom, $urandom});
			endcase
			write_imei(setting);
			phase_bytes = 0;
			while (phase_bytes < PhaseBytes) begin
				if ($urandom_range(0, 5) == 0) sender_steady = !sender_steady;
				make_value();
				phase_bytes += ext_bytes.size();
				send_value();
			end
			settle();
		end

		// hold verdicts back while short values keep arriving
		sender_steady = 1'b1;
		hold_verdicts = 1'b1;
		repeat (12) begin
			ext_bytes.delete();
			put_header(16'd1);
			ext_bytes.push_back(8'($urandom));
			send_value();
		end
		settle();

		if (mismatch_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/dilm_pkg.sv
hw/rtl/dilm_walker.sv
hw/rtl/der_imei_list_matcher_core.sv
bench/dilm_verdict_checker.sv
bench/tb_top.sv
